/* hw/rtl/tkd_pkg.sv */
// shared types and constants of the terminal key decoder
`timescale 1ns / 1ps

package tkd_pkg;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_LBRKT = 8'h5b;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_HT    = 8'd9;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] CTRL_BIAS  = 8'd96;
    localparam logic [7:0] FINAL_LO   = 8'd64;
    localparam logic [7:0] FINAL_HI   = 8'd126;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_DOWN  = 8'h42;
    localparam logic [7:0] BYTE_RIGHT = 8'h43;
    localparam logic [7:0] BYTE_LEFT  = 8'h44;

    typedef enum logic [3:0] {
        KEY_CHAR      = 4'd0,
        KEY_ESC       = 4'd1,
        KEY_UP        = 4'd2,
        KEY_DOWN      = 4'd3,
        KEY_RIGHT     = 4'd4,
        KEY_LEFT      = 4'd5,
        KEY_BACKSPACE = 4'd6,
        KEY_ENTER     = 4'd7,
        KEY_TAB       = 4'd8
    } t_key_code;

    typedef enum logic [1:0] {
        MOD_NONE = 2'd0,
        MOD_ALT  = 2'd1,
        MOD_CTRL = 2'd2
    } t_mods;

    // one decoded key event, hit low when the byte gives no event
    typedef struct packed {
        logic      hit;
        t_key_code code;
        logic [7:0] ch;
        t_mods     mods;
    } t_key;

endpackage

/* hw/rtl/tkd_intf.sv */
// valid/ready channel interfaces for raw bytes and key events
`timescale 1ns / 1ps

interface tkd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface tkd_key_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_code;
    logic [7:0] key_char;
    logic [1:0] modifiers;

    modport source (output valid, output key_code, output key_char, output modifiers,
                    input ready);
    modport sink   (input valid, input key_code, input key_char, input modifiers,
                    output ready);
endinterface

/* hw/rtl/tkd_decode.sv */
// escape sequence phase tracking and per-byte key decode
`timescale 1ns / 1ps

module tkd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output tkd_pkg::t_key o_key
);
    import tkd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_ESC       = 2'd1,
        PH_CSI_FIRST = 2'd2,
        PH_CSI_REST  = 2'd3
    } t_phase;

    t_phase r_phase;
    t_phase n_phase;
    t_phase w_phase;
    logic   w_final;

    assign w_final = (i_byte >= FINAL_LO) && (i_byte <= FINAL_HI);

    always_comb begin
        w_phase = r_phase;
        o_key   = '{hit: 1'b0, code: KEY_CHAR, ch: 8'd0, mods: MOD_NONE};
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == BYTE_ESC) begin
                    if (i_last) begin
                        o_key = '{hit: 1'b1, code: KEY_ESC, ch: 8'd0, mods: MOD_NONE};
                    end else begin
                        w_phase = PH_ESC;
                    end
                end else if (i_byte == BYTE_DEL || i_byte == BYTE_BS) begin
                    o_key = '{hit: 1'b1, code: KEY_BACKSPACE, ch: 8'd0, mods: MOD_NONE};
                end else if (i_byte == BYTE_CR || i_byte == BYTE_LF) begin
                    o_key = '{hit: 1'b1, code: KEY_ENTER, ch: 8'd0, mods: MOD_NONE};
                end else if (i_byte == BYTE_HT) begin
                    o_key = '{hit: 1'b1, code: KEY_TAB, ch: 8'd0, mods: MOD_NONE};
                end else if (i_byte < BYTE_SPACE) begin
                    // control byte below space, no carry out of eight bits
                    o_key = '{hit: 1'b1, code: KEY_CHAR, ch: i_byte + CTRL_BIAS,
                              mods: MOD_CTRL};
                end else begin
                    o_key = '{hit: 1'b1, code: KEY_CHAR, ch: i_byte, mods: MOD_NONE};
                end
            end
            PH_ESC: begin
                if (i_byte == BYTE_LBRKT) begin
                    w_phase = PH_CSI_FIRST;
                end else begin
                    o_key   = '{hit: 1'b1, code: KEY_CHAR, ch: i_byte, mods: MOD_ALT};
                    w_phase = PH_IDLE;
                end
            end
            PH_CSI_FIRST: begin
                if (w_final) begin
                    case (i_byte)
                        BYTE_UP:    o_key.code = KEY_UP;
                        BYTE_DOWN:  o_key.code = KEY_DOWN;
                        BYTE_RIGHT: o_key.code = KEY_RIGHT;
                        BYTE_LEFT:  o_key.code = KEY_LEFT;
                        default:    o_key.code = KEY_CHAR;
                    endcase
                    o_key.hit = (i_byte >= BYTE_UP) && (i_byte <= BYTE_LEFT);
                    w_phase   = PH_IDLE;
                end else begin
                    w_phase = PH_CSI_REST;
                end
            end
            default: begin
                if (w_final) begin
                    w_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign n_phase = i_last ? PH_IDLE : w_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

endmodule

/* hw/rtl/terminal_key_decoder.sv */
// top level of the terminal key decoder: input register, decode, result register
`timescale 1ns / 1ps

// Decodes raw terminal bytes, each tagged with a buffer-end mark, into key
// events. One byte is taken per cycle for as long as the result side keeps
// up. A byte passes the input register and then the result register. Its
// event is offered on the output once the result register holds it. Plain
// characters, backspace, enter, tab, ctrl and alt characters, a lone escape
// at buffer end and the four CSI arrow keys give an event; other CSI
// sequences and sequences cut off at buffer end give none, so the output
// can carry fewer transfers than the input. The one-per-cycle figure is set
// by the two-bit phase register in the decode stage, which is updated in the
// same cycle as its byte is decoded. A stalled result holds its register
// while one more byte may sit in the input register; ready falls only when
// both are full.

module terminal_key_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkd_byte_if.sink    i_byte,
    tkd_key_if.source   o_key
);
    import tkd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic       r_out_valid;
    t_key       r_out_key;

    t_key       w_key;
    logic       w_adv;
    logic       w_step;
    logic       w_in_xfer;

    // decode stage may move on when the result register is free or draining
    assign w_adv     = !r_out_valid || o_key.ready;
    assign w_step    = r_in_valid && w_adv;
    assign w_in_xfer = i_byte.valid && i_byte.ready;

    assign i_byte.ready = !r_in_valid || w_adv;

    tkd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_key   (w_key)
    );

    // input register, refilled on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_byte.byte_in;
            r_in_last <= i_byte.last_byte;
        end
    end

    // result register, bytes without an event leave it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_key.hit;
        end else if (o_key.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_key.hit) begin
            r_out_key <= w_key;
        end
    end

    assign o_key.valid     = r_out_valid;
    assign o_key.key_code  = r_out_key.code;
    assign o_key.key_char  = r_out_key.ch;
    assign o_key.modifiers = r_out_key.mods;

endmodule

/* hw/rtl/tkd_checker.sv */
// port-level assertions for the terminal key decoder and their bind
`timescale 1ns / 1ps

module tkd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_key_code,
    input  logic [7:0] i_key_char,
    input  logic [1:0] i_modifiers
);
    import tkd_pkg::*;

    // a stalled event holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_key_code)
            && $stable(i_key_char) && $stable(i_modifiers))
        else $error("stalled key event changed");

    // no event straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("key event valid after reset");

    // only char keys carry a character or a modifier
    a_named_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_code != KEY_CHAR |-> i_key_char == 8'd0
            && i_modifiers == MOD_NONE)
        else $error("named key with character or modifier");

    // ctrl always maps into the range from the backtick (96) up to DEL (127)
    a_ctrl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_modifiers == MOD_CTRL |-> i_key_code == KEY_CHAR
            && i_key_char >= CTRL_BIAS && i_key_char <= BYTE_DEL)
        else $error("ctrl key outside its range");

    // codes beyond tab and modifier three never appear
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_key_code <= KEY_TAB && i_modifiers != 2'd3)
        else $error("key code or modifier out of range");

endmodule

bind terminal_key_decoder tkd_checker u_tkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_key.valid),
    .i_out_ready (o_key.ready),
    .i_key_code  (o_key.key_code),
    .i_key_char  (o_key.key_char),
    .i_modifiers (o_key.modifiers)
);

/* tb/terminal_key_decoder_test.sv */
// self-checking test of the terminal key decoder: predicted key events against the result channel
`timescale 1ns / 1ps

module terminal_key_decoder_test;

    import tkd_pkg::*;

    // phases of the escape sequence parser, mirrored here for prediction
    typedef enum logic [1:0] {
        PHASE_IDLE      = 2'd0,
        PHASE_ESC       = 2'd1,
        PHASE_CSI_FIRST = 2'd2,
        PHASE_CSI_REST  = 2'd3
    } t_phase;

    localparam int RANDOM_BYTES = 600;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tkd_byte_if byte_ch ();
    tkd_key_if  key_ch ();

    terminal_key_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_key   (key_ch)
    );

    // predictor state and the events still owed by the block
    t_phase key_phase = PHASE_IDLE;
    t_key   pending_keys[$];

    // byte buffer under construction, with its buffer-end marks
    logic [7:0] buf_bytes[$];
    logic       buf_marks[$];

    // sender pacing: bursts of transfers separated by idle gaps
    int burst_left = 0;
    bit no_gaps    = 1'b0;

    // set by a test to make the receiver hold off for a long stretch
    bit hold_req = 1'b0;

    int fail_count     = 0;
    int bytes_sent     = 0;
    int random_sent    = 0;
    int keys_checked   = 0;
    int arrows_checked = 0;
    int alt_checked    = 0;
    int ctrl_checked   = 0;

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // generous overall time limit
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // build one key event
    function automatic t_key make_key(input t_key_code code, input logic [7:0] ch,
                                      input t_mods mods);
        t_key k;
        k.hit  = 1'b1;
        k.code = code;
        k.ch   = ch;
        k.mods = mods;
        return k;
    endfunction

    // predict the event (if any) caused by one byte and advance the phase
    function automatic t_key decode_byte(input logic [7:0] b, input logic lst);
        t_key k;
        k.hit  = 1'b0;
        k.code = KEY_CHAR;
        k.ch   = 8'd0;
        k.mods = MOD_NONE;
        case (key_phase)
            PHASE_IDLE: begin
                if (b == BYTE_ESC) begin
                    // a lone escape only counts once the buffer ends on it
                    if (lst) k = make_key(KEY_ESC, 8'd0, MOD_NONE);
                    else key_phase = PHASE_ESC;
                end else if (b == BYTE_DEL || b == BYTE_BS) begin
                    k = make_key(KEY_BACKSPACE, 8'd0, MOD_NONE);
                end else if (b == BYTE_CR || b == BYTE_LF) begin
                    k = make_key(KEY_ENTER, 8'd0, MOD_NONE);
                end else if (b == BYTE_HT) begin
                    k = make_key(KEY_TAB, 8'd0, MOD_NONE);
                end else if (b < BYTE_SPACE) begin
                    k = make_key(KEY_CHAR, b + CTRL_BIAS, MOD_CTRL);
                end else begin
                    k = make_key(KEY_CHAR, b, MOD_NONE);
                end
            end
            PHASE_ESC: begin
                if (b == BYTE_LBRKT) begin
                    key_phase = PHASE_CSI_FIRST;
                end else begin
                    // includes a second escape, which gives alt plus escape
                    k = make_key(KEY_CHAR, b, MOD_ALT);
                    key_phase = PHASE_IDLE;
                end
            end
            PHASE_CSI_FIRST: begin
                if (b >= FINAL_LO && b <= FINAL_HI) begin
                    // only a final byte straight after the bracket can be an arrow
                    if (b == BYTE_UP) k = make_key(KEY_UP, 8'd0, MOD_NONE);
                    else if (b == BYTE_DOWN) k = make_key(KEY_DOWN, 8'd0, MOD_NONE);
                    else if (b == BYTE_RIGHT) k = make_key(KEY_RIGHT, 8'd0, MOD_NONE);
                    else if (b == BYTE_LEFT) k = make_key(KEY_LEFT, 8'd0, MOD_NONE);
                    key_phase = PHASE_IDLE;
                end else begin
                    key_phase = PHASE_CSI_REST;
                end
            end
            default: begin
                if (b >= FINAL_LO && b <= FINAL_HI) key_phase = PHASE_IDLE;
            end
        endcase
        // buffer end always drops back to idle, cutting off any sequence
        if (lst) key_phase = PHASE_IDLE;
        return k;
    endfunction

    // offer one byte, wait for its transfer, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int   gap;
        t_key k;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= b;
        byte_ch.last_byte <= lst;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
        k = decode_byte(b, lst);
        if (k.hit) pending_keys.push_back(k);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic lst);
        buf_bytes.push_back(b);
        buf_marks.push_back(lst);
    endtask

    // send the buffer under construction and empty it
    task automatic flush_buffer();
        int i;
        for (i = 0; i < buf_bytes.size(); i++) send_byte(buf_bytes[i], buf_marks[i]);
        buf_bytes.delete();
        buf_marks.delete();
    endtask

    // compare one event transfer with the oldest prediction
    task automatic check_key();
        t_key k;
        if (pending_keys.size() == 0) begin
            $error("key event with no byte to account for it: code %0d char %0d mods %0d",
                   key_ch.key_code, key_ch.key_char, key_ch.modifiers);
            fail_count++;
        end else begin
            k = pending_keys.pop_front();
            keys_checked++;
            if (k.code inside {KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT}) arrows_checked++;
            if (k.mods == MOD_ALT) alt_checked++;
            if (k.mods == MOD_CTRL) ctrl_checked++;
            if (key_ch.key_code !== k.code) begin
                $error("key_code: expected %0d, actual %0d", k.code, key_ch.key_code);
                fail_count++;
            end
            if (key_ch.key_char !== k.ch) begin
                $error("key_char: expected %0d, actual %0d", k.ch, key_ch.key_char);
                fail_count++;
            end
            if (key_ch.modifiers !== k.mods) begin
                $error("modifiers: expected %0d, actual %0d", k.mods, key_ch.modifiers);
                fail_count++;
            end
        end
    endtask

    // receiver: checks every event transfer and stalls on a pattern of its own,
    // whose stall rate is redrawn from 0, 30, 60 and 90 percent and is sometimes zero
    initial begin
        int hold_left;
        int cycle;
        int stall_pct;
        hold_left = 0;
        cycle     = 0;
        stall_pct = 0;
        key_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && key_ch.ready && key_ch.valid !== 1'b0) check_key();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (cycle % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    3: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            cycle++;
            if (hold_left > 0) begin
                hold_left--;
                key_ch.ready <= 1'b0;
            end else begin
                key_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // single bytes: control range ends, the named control keys, space, DEL, top byte
    task automatic test_single_bytes();
        add_byte(8'd0, 1'b0);
        add_byte(BYTE_BS, 1'b0);
        add_byte(BYTE_HT, 1'b0);
        add_byte(BYTE_LF, 1'b0);
        add_byte(BYTE_CR, 1'b0);
        add_byte(8'd31, 1'b0);
        add_byte(BYTE_SPACE, 1'b0);
        add_byte(BYTE_DEL, 1'b0);
        add_byte(8'd255, 1'b1);
        flush_buffer();
    endtask

    // escape handling: lone escape at buffer end, escape then escape, alt char
    task automatic test_escape_keys();
        add_byte(BYTE_ESC, 1'b1);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(8'h71, 1'b1);
        flush_buffer();
    endtask

    // the four arrows in one buffer
    task automatic test_arrow_keys();
        int i;
        for (i = 0; i < 4; i++) begin
            add_byte(BYTE_ESC, 1'b0);
            add_byte(BYTE_LBRKT, 1'b0);
            add_byte(BYTE_UP + i[7:0], i == 3);
        end
        flush_buffer();
    endtask

    // csi sequences that give nothing: other final byte, cut off at buffer end
    task automatic test_silent_csi();
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_LBRKT, 1'b0);
        add_byte(8'h5a, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_LBRKT, 1'b1);
        flush_buffer();
    endtask

    // receiver holds off while the sender keeps offering bytes back to back
    task automatic test_backpressure();
        int i;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (i = 0; i < 30; i++) add_byte(8'($urandom_range(32, 126)), 1'b0);
        flush_buffer();
        no_gaps = 1'b0;
    endtask

    // mostly well-formed sequences with random content, plus noise and cut buffers
    task automatic test_random_traffic();
        int kind;
        int n;
        int i;
        while (random_sent < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 40) begin
                add_byte(8'($urandom_range(0, 31)), 1'b0);
            end else if (kind < 55) begin
                add_byte(BYTE_ESC, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 75) begin
                add_byte(BYTE_ESC, 1'b0);
                add_byte(BYTE_LBRKT, 1'b0);
                add_byte(BYTE_UP + 8'($urandom_range(0, 3)), 1'b0);
            end else if (kind < 90) begin
                // parameter bytes then any final byte
                add_byte(BYTE_ESC, 1'b0);
                add_byte(BYTE_LBRKT, 1'b0);
                n = $urandom_range(0, 3);
                repeat (n) add_byte(8'($urandom_range(32, 63)), 1'b0);
                add_byte(8'($urandom_range(FINAL_LO, FINAL_HI)), 1'b0);
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            // buffer end after the sequence, or a cut somewhere inside it
            if ($urandom_range(0, 3) == 0) buf_marks[buf_marks.size() - 1] = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                i = $urandom_range(0, buf_marks.size() - 1);
                buf_marks[i] = 1'b1;
            end
            random_sent += buf_bytes.size();
            flush_buffer();
        end
    endtask

    // let the owed events arrive, then wait out a tail for stray ones
    task automatic wait_for_keys();
        int spins;
        spins = 0;
        while (pending_keys.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        byte_ch.valid     <= 1'b0;
        byte_ch.byte_in   <= 8'd0;
        byte_ch.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_escape_keys();
        test_arrow_keys();
        test_silent_csi();
        test_backpressure();
        test_random_traffic();

        // last transfer has happened: stop offering
        byte_ch.valid <= 1'b0;
        wait_for_keys();

        if (pending_keys.size() != 0) begin
            $error("%0d predicted key events never arrived", pending_keys.size());
            fail_count++;
        end

        $display("%0d bytes in, %0d key events checked", bytes_sent, keys_checked);
        $display("of those %0d arrows, %0d alt, %0d ctrl; one long result-side hold",
                 arrows_checked, alt_checked, ctrl_checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* terminal_key_decoder.f */
hw/rtl/tkd_pkg.sv
hw/rtl/tkd_intf.sv
hw/rtl/tkd_decode.sv
hw/rtl/terminal_key_decoder.sv
hw/rtl/tkd_checker.sv
tb/terminal_key_decoder_test.sv
